/* rtl/core/fcc_pkg.sv */
`timescale 1ns / 1ps
// Package for the frame checker: constants, codes, config struct and CRC-32 byte update.
// No dependencies.
package fcc_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int CRC_BYTES    = 4;
  localparam int COUNT_W      = 22;
  localparam int LEN_W        = 32;
  localparam int PLEN_W       = 21;
  localparam int PADDR_W      = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [31:0]        CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0]        CRC_INIT  = 32'hFFFF_FFFF;

  localparam logic [31:0]        MAGIC_RST   = 32'h0000_0000;
  localparam logic [7:0]         VERSION_RST = 8'd1;
  localparam logic [PLEN_W-1:0]  MAX_PAY_RST = 21'd1048576;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INCOMPLETE  = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_TOO_LONG    = 3'd4,
    ST_LEN_MISMATCH = 3'd5,
    ST_CRC_MISMATCH = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    HERR_NONE    = 2'd0,
    HERR_MAGIC   = 2'd1,
    HERR_VERSION = 2'd2,
    HERR_LENGTH  = 2'd3
  } herr_t;

  typedef enum logic [1:0] {
    REG_MAGIC   = 2'd0,
    REG_VERSION = 2'd1,
    REG_MAX_PAY = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]       magic_word;
    logic [7:0]        major_version;
    logic [PLEN_W-1:0] max_payload;
  } cfg_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/fcc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the frame checker: received bytes in, results out.
// Depends on fcc_pkg for field widths.
interface fcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface fcc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [7:0]                  payload_byte;
  logic [15:0]                 msg_type;
  logic [63:0]                 correlation;
  logic [fcc_pkg::PLEN_W-1:0]  frame_len;
  logic [2:0]                  status;
  logic                        done_res;

  modport source (output valid, output kind, output payload_byte, output msg_type,
                  output correlation, output frame_len, output status,
                  output done_res, input ready);
  modport sink   (input valid, input kind, input payload_byte, input msg_type,
                  input correlation, input frame_len, input status,
                  input done_res, output ready);
endinterface

/* rtl/core/fcc_cfg_regs.sv */
`timescale 1ns / 1ps
// APB-style configuration registers: magic word, major version, max payload.
// Depends on fcc_pkg.
module fcc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output fcc_pkg::cfg_t               cfg
);
  import fcc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MAGIC:   cfg_nxt.magic_word    = pwdata;
        REG_VERSION: cfg_nxt.major_version = pwdata[7:0];
        REG_MAX_PAY: cfg_nxt.max_payload   = pwdata[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAGIC:   prdata = cfg_r.magic_word;
      REG_VERSION: prdata = {24'd0, cfg_r.major_version};
      REG_MAX_PAY: prdata = {{(32-PLEN_W){1'b0}}, cfg_r.max_payload};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_word    <= MAGIC_RST;
      cfg_r.major_version <= VERSION_RST;
      cfg_r.max_payload   <= MAX_PAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/core/fcc_deframer.sv */
`timescale 1ns / 1ps
// Deframer datapath: input register, header/payload/CRC state update, result register.
// Depends on fcc_pkg and the channel interfaces in fcc_if.
module fcc_deframer (
  input  logic          clk,
  input  logic          rst_n,
  input  fcc_pkg::cfg_t cfg,
  fcc_in_if.sink        in_if,
  fcc_out_if.source     out_if
);
  import fcc_pkg::*;

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       advance;

  // frame state
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]        crc_r, crc_nxt;
  logic [31:0]        rcrc_r, rcrc_nxt;
  logic [15:0]        type_r, type_nxt;
  logic [63:0]        corr_r, corr_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  herr_t              err_r, err_nxt;

  // result register
  logic              out_valid_r;
  logic              kind_r, kind_nxt;
  logic [7:0]        pbyte_r, pbyte_nxt;
  logic [15:0]       mtype_r;
  logic [63:0]       mcorr_r;
  logic [PLEN_W-1:0] plen_r, plen_nxt;
  status_t           st_r, st_nxt;
  logic              has_res;

  assign advance     = s1_valid_r & (~out_valid_r | out_if.ready);
  assign in_if.ready = ~s1_valid_r | advance;

  always_comb begin
    logic [COUNT_W-1:0] idx;
    logic [LEN_W:0]     pay_end;
    logic [LEN_W:0]     idx_ext;
    logic [LEN_W:0]     end_pos;
    logic [1:0]         off;
    logic [7:0]         b;
    logic               is_payload;

    idx        = cnt_r;
    b          = s1_byte_r;
    is_payload = 1'b0;
    crc_nxt    = crc_r;
    rcrc_nxt   = rcrc_r;
    type_nxt   = type_r;
    corr_nxt   = corr_r;
    len_nxt    = len_r;
    err_nxt    = err_r;
    pay_end    = {1'b0, len_r} + (LEN_W+1)'(HEADER_BYTES);
    idx_ext    = (LEN_W+1)'(idx);
    off        = idx[1:0] - pay_end[1:0];

    if (idx < COUNT_W'(HEADER_BYTES)) begin
      crc_nxt = crc_byte(crc_r, b);
      priority if (idx < COUNT_W'(4)) begin
        if (err_r == HERR_NONE && b != cfg.magic_word[{idx[1:0], 3'b000} +: 8])
          err_nxt = HERR_MAGIC;
      end else if (idx == COUNT_W'(4)) begin
        if (err_r == HERR_NONE && b != cfg.major_version)
          err_nxt = HERR_VERSION;
      end else if (idx == COUNT_W'(5)) begin
        err_nxt = err_r;
      end else if (idx < COUNT_W'(8)) begin
        type_nxt[{idx[0], 3'b000} +: 8] = type_r[{idx[0], 3'b000} +: 8] | b;
      end else if (idx < COUNT_W'(16)) begin
        corr_nxt[{idx[2:0], 3'b000} +: 8] = corr_r[{idx[2:0], 3'b000} +: 8] | b;
      end else begin
        len_nxt[{idx[1:0], 3'b000} +: 8] = len_r[{idx[1:0], 3'b000} +: 8] | b;
        if (idx == COUNT_W'(HEADER_BYTES - 1) && err_r == HERR_NONE
            && len_nxt > LEN_W'(cfg.max_payload))
          err_nxt = HERR_LENGTH;
      end
    end else if (err_r == HERR_NONE && idx < COUNT_MAX) begin
      if (idx_ext < pay_end) begin
        crc_nxt    = crc_byte(crc_r, b);
        is_payload = 1'b1;
      end else if (idx_ext < pay_end + (LEN_W+1)'(CRC_BYTES)) begin
        rcrc_nxt[{off, 3'b000} +: 8] = rcrc_r[{off, 3'b000} +: 8] | b;
      end
    end

    cnt_nxt = (cnt_r < COUNT_MAX) ? cnt_r + 1'b1 : cnt_r;

    plen_nxt = (cnt_nxt >= COUNT_W'(HEADER_BYTES) && err_nxt == HERR_NONE) ?
               len_nxt[PLEN_W-1:0] : '0;

    end_pos = {1'b0, len_nxt} + (LEN_W+1)'(HEADER_BYTES + CRC_BYTES);
    priority if (cnt_nxt < COUNT_W'(HEADER_BYTES + CRC_BYTES)) begin
      st_nxt = ST_INCOMPLETE;
    end else if (err_nxt != HERR_NONE) begin
      unique case (err_nxt)
        HERR_MAGIC:   st_nxt = ST_BAD_MAGIC;
        HERR_VERSION: st_nxt = ST_BAD_VERSION;
        default:      st_nxt = ST_TOO_LONG;
      endcase
    end else if ((LEN_W+1)'(cnt_nxt) < end_pos) begin
      st_nxt = ST_INCOMPLETE;
    end else if ((LEN_W+1)'(cnt_nxt) != end_pos) begin
      st_nxt = ST_LEN_MISMATCH;
    end else if ((crc_nxt ^ CRC_INIT) != rcrc_nxt) begin
      st_nxt = ST_CRC_MISMATCH;
    end else begin
      st_nxt = ST_OK;
    end

    if (s1_last_r) begin
      kind_nxt  = KIND_STATUS;
      pbyte_nxt = 8'd0;
    end else begin
      kind_nxt  = KIND_PAYLOAD;
      pbyte_nxt = b;
      st_nxt    = ST_OK;
    end
    has_res = s1_last_r | is_payload;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_byte_r <= in_if.rx_byte;
      s1_last_r <= in_if.buffer_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      crc_r  <= CRC_INIT;
      rcrc_r <= '0;
      type_r <= '0;
      corr_r <= '0;
      len_r  <= '0;
      err_r  <= HERR_NONE;
    end else if (advance) begin
      if (s1_last_r) begin
        cnt_r  <= '0;
        crc_r  <= CRC_INIT;
        rcrc_r <= '0;
        type_r <= '0;
        corr_r <= '0;
        len_r  <= '0;
        err_r  <= HERR_NONE;
      end else begin
        cnt_r  <= cnt_nxt;
        crc_r  <= crc_nxt;
        rcrc_r <= rcrc_nxt;
        type_r <= type_nxt;
        corr_r <= corr_nxt;
        len_r  <= len_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= has_res;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_res) begin
      kind_r  <= kind_nxt;
      pbyte_r <= pbyte_nxt;
      mtype_r <= type_nxt;
      mcorr_r <= corr_nxt;
      plen_r  <= plen_nxt;
      st_r    <= st_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = kind_r;
  assign out_if.payload_byte = pbyte_r;
  assign out_if.msg_type     = mtype_r;
  assign out_if.correlation  = mcorr_r;
  assign out_if.frame_len    = plen_r;
  assign out_if.status       = st_r;
  assign out_if.done_res     = kind_r;

endmodule

/* rtl/core/frame_checker_with_crc32.sv */
`timescale 1ns / 1ps
// Frame checker top level: length-prefixed frame deframer with CRC-32 check.
// Depends on fcc_pkg, fcc_if, fcc_cfg_regs and fcc_deframer.
//
// Usage:
//   in_if carries one received byte per word; buffer_end marks the last byte.
//   out_if gives payload bytes (kind 0) as they arrive, and one status word
//   (kind 1, done_res 1) on the last byte, with the header fields.
//   Configuration (magic, major version, max payload) is written over the
//   APB-style port at byte addresses 0, 4 and 8 while no frame is in flight.
// Timing:
//   One byte per cycle sustained while out_if.ready is high. The byte enters
//   the input register when accepted, and the result register loads from it
//   when the result is offered; the CRC-32 byte update and header checks sit between.
// Reset:
//   rst_n low clears frame state and the valid flags of both pipeline
//   registers, and restores the configuration registers to their defaults.
// Stall:
//   When out_if.ready is low with a result waiting, the input register holds
//   one more byte and then in_if.ready drops until the result is taken.
module frame_checker_with_crc32 (
  input  logic                        clk,
  input  logic                        rst_n,
  fcc_in_if.sink                      in_if,
  fcc_out_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fcc_pkg::*;

  cfg_t cfg;

  fcc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fcc_deframer u_deframer (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_if  (in_if),
    .out_if (out_if)
  );

`ifndef ASSERT_OFF
  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind == KIND_PAYLOAD) |->
      (out_if.status == ST_OK && !out_if.done_res))
    else $error("payload word carries status");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (out_if.valid && !out_if.ready))
    else $error("input stalled without output backpressure");

  a_hdr_err_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind == KIND_STATUS &&
     (out_if.status == ST_BAD_MAGIC || out_if.status == ST_BAD_VERSION ||
      out_if.status == ST_TOO_LONG)) |-> (out_if.frame_len == '0))
    else $error("length reported on header error");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("output valid after reset");
`endif

endmodule
